[hdl/nnfs_pkg.sv]
// Shared constants of the nearest-neighbour frame scaler.
package nnfs_pkg;

    localparam int FRAC_BITS   = 16;   // fraction bits of a step (6.16 at the default 60x60 source)
    localparam int DIM_W       = 11;   // screen size register width
    localparam int PIXEL_W     = 16;   // RGB565 pixel
    localparam int COORD_W     = 12;   // signed destination coordinate
    localparam int INDEX_W     = 12;   // source load address
    localparam int DIM_RESET   = 240;  // screen size after reset
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    localparam logic AXIS_COL = 1'b0;
    localparam logic AXIS_ROW = 1'b1;

endpackage

[hdl/nnfs_div.sv]
// Restoring divider, one quotient bit per cycle, for the fixed-point steps (6.16 at the default NUM_W of 22).
module nnfs_div
    import nnfs_pkg::*;
#(
    parameter int NUM_W = 22
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NUM_W-1:0]   numer,
    input  logic [DIM_W-1:0]   denom,
    output logic               busy,
    output logic               done,
    output logic [NUM_W-1:0]   quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;
    logic [DIM_W-1:0] rem_reg;
    logic [DIM_W-1:0] rem_next;
    logic [DIM_W-1:0] den_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DIM_W:0]   trial;
    logic             fits;

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign quot = q_reg;

    always_comb
    begin
        trial    = {rem_reg, q_reg[NUM_W-1]};
        fits     = (trial >= {1'b0, den_reg});
        // remainder stays below the divisor, so it fits the divisor width
        rem_next = fits ? DIM_W'(trial - {1'b0, den_reg}) : trial[DIM_W-1:0];
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        done_next = busy && (cnt_reg == CNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (busy)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

endmodule

[hdl/nnfs_step.sv]
// Screen size registers and the column and row steps derived from them.
module nnfs_step
    import nnfs_pkg::*;
#(
    parameter int SRC_WIDTH  = 60,
    parameter int SRC_HEIGHT = 60,
    parameter int NUM_W      = 22
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output logic                 stall,
    output logic [NUM_W-1:0]     col_step,
    output logic [NUM_W-1:0]     row_step
);

    localparam logic [NUM_W-1:0] COL_NUM = NUM_W'(SRC_WIDTH << FRAC_BITS);
    localparam logic [NUM_W-1:0] ROW_NUM = NUM_W'(SRC_HEIGHT << FRAC_BITS);
    localparam logic [NUM_W-1:0] COL_RST = NUM_W'((SRC_WIDTH << FRAC_BITS) / DIM_RESET);
    localparam logic [NUM_W-1:0] ROW_RST = NUM_W'((SRC_HEIGHT << FRAC_BITS) / DIM_RESET);

    logic [DIM_W-1:0] scr_w_reg;
    logic [DIM_W-1:0] scr_h_reg;
    logic             pend_col_reg;
    logic             pend_col_next;
    logic             pend_row_reg;
    logic             pend_row_next;
    logic             axis_reg;
    logic             axis_next;
    logic [NUM_W-1:0] col_step_reg;
    logic [NUM_W-1:0] row_step_reg;

    logic             div_start;
    logic             div_busy;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;
    logic [NUM_W-1:0] div_numer;
    logic [DIM_W-1:0] div_size;
    logic [DIM_W-1:0] div_denom;

    assign col_step = col_step_reg;
    assign row_step = row_step_reg;
    assign stall    = cfg_we || pend_col_reg || pend_row_reg || div_busy || div_done;

    always_comb
    begin
        div_start = !div_busy && !div_done && (pend_col_reg || pend_row_reg);
        axis_next = axis_reg;
        if (div_start)
        begin
            axis_next = pend_col_reg ? AXIS_COL : AXIS_ROW;
        end
        div_numer = (axis_next == AXIS_COL) ? COL_NUM : ROW_NUM;
        div_size  = (axis_next == AXIS_COL) ? scr_w_reg : scr_h_reg;
        // a zero size divides as one
        div_denom = (div_size == '0) ? DIM_W'(1) : div_size;

        pend_col_next = pend_col_reg;
        pend_row_next = pend_row_reg;
        if (div_start && axis_next == AXIS_COL)
        begin
            pend_col_next = 1'b0;
        end
        if (div_start && axis_next == AXIS_ROW)
        begin
            pend_row_next = 1'b0;
        end
        if (cfg_we && cfg_index == REG_SCREEN_WIDTH)
        begin
            pend_col_next = 1'b1;
        end
        if (cfg_we && cfg_index == REG_SCREEN_HEIGHT)
        begin
            pend_row_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg    <= DIM_W'(DIM_RESET);
            scr_h_reg    <= DIM_W'(DIM_RESET);
            pend_col_reg <= 1'b0;
            pend_row_reg <= 1'b0;
            axis_reg     <= AXIS_COL;
            col_step_reg <= COL_RST;
            row_step_reg <= ROW_RST;
        end
        else
        begin
            pend_col_reg <= pend_col_next;
            pend_row_reg <= pend_row_next;
            axis_reg     <= axis_next;
            if (cfg_we && cfg_index == REG_SCREEN_WIDTH)
            begin
                scr_w_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_SCREEN_HEIGHT)
            begin
                scr_h_reg <= cfg_data;
            end
            if (div_done && axis_reg == AXIS_COL)
            begin
                col_step_reg <= div_quot;
            end
            if (div_done && axis_reg == AXIS_ROW)
            begin
                row_step_reg <= div_quot;
            end
        end
    end

    nnfs_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

endmodule

[hdl/nnfs_front.sv]
// Front end: accept items, scale coordinates and form frame addresses.
module nnfs_front
    import nnfs_pkg::*;
#(
    parameter int SRC_WIDTH  = 60,
    parameter int SRC_HEIGHT = 60,
    parameter int NUM_W      = 22,
    parameter int AW         = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_mode,
    input  logic [INDEX_W-1:0] in_index,
    input  logic [PIXEL_W-1:0] in_pixel,
    input  logic [COORD_W-1:0] in_x,
    input  logic [COORD_W-1:0] in_y,
    input  logic               stall,
    input  logic [NUM_W-1:0]   col_step,
    input  logic [NUM_W-1:0]   row_step,
    output logic               push_valid,
    input  logic               push_ready,
    output logic               push_load,
    output logic [AW-1:0]      push_addr,
    output logic [PIXEL_W-1:0] push_data
);

    localparam int FRAME_DEPTH = SRC_WIDTH * SRC_HEIGHT;
    localparam int PW = COORD_W - 1 + NUM_W;
    localparam int QW = PW - FRAC_BITS;
    localparam int XW = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
    localparam int YW = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;

    logic               s1_v_reg;
    logic               s1_v_next;
    logic               s1_load_reg;
    logic               s1_ok_reg;
    logic [INDEX_W-1:0] s1_idx_reg;
    logic [PIXEL_W-1:0] s1_pix_reg;
    logic               s1_xneg_reg;
    logic               s1_yneg_reg;
    logic [PW-1:0]      s1_px_reg;
    logic [PW-1:0]      s1_py_reg;

    logic               s2_v_reg;
    logic               s2_v_next;
    logic               s2_load_reg;
    logic [AW-1:0]      s2_addr_reg;
    logic [PIXEL_W-1:0] s2_data_reg;

    logic               s1_ready;
    logic               s2_ready;
    logic               accept;
    logic               s1_keep;
    logic [QW-1:0]      qx;
    logic [QW-1:0]      qy;
    logic [XW-1:0]      fx;
    logic [YW-1:0]      fy;
    logic [AW-1:0]      fetch_addr;

    assign s2_ready = !s2_v_reg || push_ready;
    assign s1_ready = !s1_v_reg || s2_ready;
    assign in_ready = s1_ready && !stall;
    assign accept   = in_valid && in_ready;

    // drop loads that fall outside the frame
    assign s1_keep  = (s1_load_reg != MODE_LOAD) || s1_ok_reg;

    assign push_valid = s2_v_reg;
    assign push_load  = s2_load_reg;
    assign push_addr  = s2_addr_reg;
    assign push_data  = s2_data_reg;

    always_comb
    begin
        qx = s1_px_reg[FRAC_BITS +: QW];
        qy = s1_py_reg[FRAC_BITS +: QW];
        if (s1_xneg_reg)
        begin
            fx = '0;
        end
        else if (qx >= QW'(SRC_WIDTH))
        begin
            fx = XW'(SRC_WIDTH - 1);
        end
        else
        begin
            fx = qx[XW-1:0];
        end
        if (s1_yneg_reg)
        begin
            fy = '0;
        end
        else if (qy >= QW'(SRC_HEIGHT))
        begin
            fy = YW'(SRC_HEIGHT - 1);
        end
        else
        begin
            fy = qy[YW-1:0];
        end
        fetch_addr = AW'(fy) * AW'(SRC_WIDTH) + AW'(fx);

        s1_v_next = s1_ready ? accept : s1_v_reg;
        s2_v_next = s2_ready ? (s1_v_reg && s1_keep) : s2_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_load_reg <= in_mode;
            s1_ok_reg   <= (32'(in_index) < 32'(FRAME_DEPTH));
            s1_idx_reg  <= in_index;
            s1_pix_reg  <= in_pixel;
            s1_xneg_reg <= in_x[COORD_W-1];
            s1_yneg_reg <= in_y[COORD_W-1];
            s1_px_reg   <= PW'(in_x[COORD_W-2:0]) * PW'(col_step);
            s1_py_reg   <= PW'(in_y[COORD_W-2:0]) * PW'(row_step);
        end
        if (s2_ready)
        begin
            s2_load_reg <= s1_load_reg;
            s2_data_reg <= s1_pix_reg;
            s2_addr_reg <= (s1_load_reg == MODE_LOAD) ? AW'(s1_idx_reg) : fetch_addr;
        end
    end

endmodule

[hdl/nnfs_queue.sv]
// Short first-in first-out queue between front and back ends.
module nnfs_queue
    import nnfs_pkg::*;
#(
    parameter int EW = 29
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  logic [EW-1:0] push_entry,
    output logic          pop_valid,
    input  logic          pop_ready,
    output logic [EW-1:0] pop_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [EW-1:0]    slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[hdl/nnfs_back.sv]
// Back end: source frame memory, loads and pixel fetches, output register.
module nnfs_back
    import nnfs_pkg::*;
#(
    parameter int SRC_WIDTH  = 60,
    parameter int SRC_HEIGHT = 60,
    parameter int AW         = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  logic               pop_load,
    input  logic [AW-1:0]      pop_addr,
    input  logic [PIXEL_W-1:0] pop_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIXEL_W-1:0] out_pixel
);

    localparam int FRAME_DEPTH = SRC_WIDTH * SRC_HEIGHT;

    logic [PIXEL_W-1:0] frame_mem [FRAME_DEPTH];
    logic [PIXEL_W-1:0] pixel_reg;
    logic               out_v_reg;
    logic               out_v_next;
    logic               do_pop;
    logic               do_write;
    logic               do_read;

    // a load needs no output slot; a fetch waits until the output register frees
    assign pop_ready = (pop_load == MODE_LOAD) || !out_v_reg || out_ready;
    assign do_pop    = pop_valid && pop_ready;
    assign do_write  = do_pop && (pop_load == MODE_LOAD);
    assign do_read   = do_pop && (pop_load == MODE_FETCH);
    assign out_valid = out_v_reg;
    assign out_pixel = pixel_reg;

    always_comb
    begin
        out_v_next = out_v_reg;
        if (do_read)
        begin
            out_v_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            frame_mem[pop_addr] <= pop_data;
        end
        if (do_read)
        begin
            pixel_reg <= frame_mem[pop_addr];
        end
    end

endmodule

[hdl/nearest_neighbor_frame_scaler_unit.sv]
// Nearest-neighbour frame scaler: top level.
//
// Holds a SRC_WIDTH x SRC_HEIGHT RGB565 frame written by load items
// (tuser low) and answers fetch items (tuser high) with the source pixel
// nearest to destination (x,y), using fixed-point steps (6.16 at the default
// 60x60 source) of source size over screen size. One item is taken per clock
// while s_tready is high; a fetch passes two front stages (coordinate
// multiply, then clamp and address), the queue, and the registered frame
// memory read. Loads give no result and loads outside the frame are dropped.
// A write to a screen size register recomputes that step in a shift-subtract
// divider, one quotient bit per clock; s_tready stays low for the write
// cycle and after it until the step of each register written is recomputed.
module nearest_neighbor_frame_scaler_unit
    import nnfs_pkg::*;
#(
    parameter int SRC_WIDTH  = 60,
    parameter int SRC_HEIGHT = 60
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [55:0]          s_tdata,   // source_index, source_pixel, dest_x, dest_y
    input  logic                 s_tuser,   // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // pixel
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam int SRC_MAX     = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
    localparam int NUM_W       = $clog2(SRC_MAX + 1) + FRAC_BITS;
    localparam int FRAME_DEPTH = SRC_WIDTH * SRC_HEIGHT;
    localparam int AW          = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int EW          = 1 + AW + PIXEL_W;

    logic               stall;
    logic [NUM_W-1:0]   col_step;
    logic [NUM_W-1:0]   row_step;

    logic               push_valid;
    logic               push_ready;
    logic               push_load;
    logic [AW-1:0]      push_addr;
    logic [PIXEL_W-1:0] push_data;

    logic               pop_valid;
    logic               pop_ready;
    logic [EW-1:0]      pop_entry;

    nnfs_step #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .NUM_W      (NUM_W)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stall     (stall),
        .col_step  (col_step),
        .row_step  (row_step)
    );

    nnfs_front #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .NUM_W      (NUM_W),
        .AW         (AW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_index   (s_tdata[11:0]),
        .in_pixel   (s_tdata[27:12]),
        .in_x       (s_tdata[39:28]),
        .in_y       (s_tdata[51:40]),
        .stall      (stall),
        .col_step   (col_step),
        .row_step   (row_step),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_load  (push_load),
        .push_addr  (push_addr),
        .push_data  (push_data)
    );

    nnfs_queue #(
        .EW (EW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry ({push_load, push_addr, push_data}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    nnfs_back #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT),
        .AW         (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_load  (pop_entry[EW-1]),
        .pop_addr  (pop_entry[PIXEL_W +: AW]),
        .pop_data  (pop_entry[PIXEL_W-1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (m_tdata)
    );

endmodule

[hdl/nnfs_checker.sv]
// Port-level checks of the frame scaler, bound to the top level.
module nnfs_checker
    import nnfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [15:0]          m_tdata,
    input  logic                 cfg_we
);

    logic [7:0] owed_reg;
    logic       fetch_in;
    logic       pixel_out;

    assign fetch_in  = s_tvalid && s_tready && (s_tuser == MODE_FETCH);
    assign pixel_out = m_tvalid && m_tready;

    // count fetches whose pixel has not yet been transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_reg <= '0;
        end
        else if (fetch_in && !pixel_out)
        begin
            owed_reg <= owed_reg + 8'd1;
        end
        else if (pixel_out && !fetch_in)
        begin
            owed_reg <= owed_reg - 8'd1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    a_cfg_blocks_now: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> !s_tready)
        else $error("input taken during a register write");

    a_cfg_blocks_next: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_tready)
        else $error("input taken before the step was recomputed");

    a_no_spurious_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> owed_reg != 8'd0)
        else $error("pixel offered with no fetch outstanding");

endmodule

bind nearest_neighbor_frame_scaler_unit nnfs_checker u_nnfs_checker (.*);
